[design/trht_pkg.sv]
// Shared types, codes and field layouts of the touch region hit table.
package trht_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_PRESS   = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // Event codes carried on the output tuser
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_CLICK   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LOST    = 2'd3;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 48;
    localparam int COUNT_W     = 5;

    // One request, last member in the lowest bits
    typedef struct packed {
        logic [15:0] touch_y;
        logic [15:0] touch_x;
        logic        has_release_action;
        logic        has_press_action;
        logic [7:0]  area_tag;
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
    } t_item;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic        down;
        logic        rel_act;
        logic        press_act;
        logic [7:0]  tag;
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
    } t_entry;

    // Result fields that travel in the output tdata
    typedef struct packed {
        logic [COUNT_W-1:0] area_count;
        logic               add_ok;
        logic               handled;
        logic [15:0]        event_y;
        logic [15:0]        event_x;
        logic [7:0]         hit_tag;
    } t_res_data;

    typedef struct packed {
        logic [1:0] event_res;
        t_res_data  data;
    } t_result;

endpackage

[design/trht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module trht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, and register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/trht_seq.sv]
// Request sequencer: table count, add writes and the read-modify-write entry scan.
module trht_seq
    import trht_pkg::*;
#(
    parameter int MAX_AREAS = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_in_valid,
    output logic                                           o_in_ready,
    input  logic [1:0]                                     i_op,
    input  t_item                                          i_item,
    input  logic                                           i_lfe,
    output logic [((MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1)-1:0] o_rd_addr,
    input  t_entry                                         i_rd_data,
    output logic                                           o_we,
    output logic [((MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1)-1:0] o_wr_addr,
    output t_entry                                         o_wr_data,
    output logic                                           o_res_valid,
    input  logic                                           i_res_take,
    output t_result                                        o_res
);

    localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int CW = $clog2(MAX_AREAS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_eidx, n_eidx;
    logic [1:0]    r_op, n_op;
    logic [15:0]   r_x, n_x;
    logic [15:0]   r_y, n_y;
    logic [1:0]    r_ev, n_ev;
    logic [7:0]    r_tag, n_tag;
    logic          r_handled, n_handled;
    logic          r_ok, n_ok;

    logic   hit;
    logic   last;
    logic   stop;
    logic   touch_op;
    t_entry new_entry;

    // Containment of the touch point in the entry just read
    assign hit = (r_x >= i_rd_data.left) && (r_x <= i_rd_data.right) &&
                 (r_y >= i_rd_data.top)  && (r_y <= i_rd_data.bottom);
    assign last = (CW'(CW'(r_eidx) + CW'(1)) == r_count);
    assign touch_op = (r_op == OP_PRESS) || (r_op == OP_RELEASE);

    // Fresh entry built from an add request
    always_comb begin
        new_entry           = '0;
        new_entry.left      = i_item.left;
        new_entry.top       = i_item.top;
        new_entry.right     = i_item.right;
        new_entry.bottom    = i_item.bottom;
        new_entry.tag       = i_item.area_tag;
        new_entry.press_act = i_item.has_press_action;
        new_entry.rel_act   = i_item.has_release_action;
        new_entry.down      = 1'b0;
    end

    // Next state, RAM access and result bookkeeping
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_eidx    = r_eidx;
        n_op      = r_op;
        n_x       = r_x;
        n_y       = r_y;
        n_ev      = r_ev;
        n_tag     = r_tag;
        n_handled = r_handled;
        n_ok      = r_ok;
        stop      = 1'b0;
        o_rd_addr = AW'(r_eidx + AW'(1));
        o_we      = 1'b0;
        o_wr_addr = AW'(r_count);
        o_wr_data = new_entry;

        unique case (r_state)
            S_IDLE: begin
                o_rd_addr = '0;
                if (i_in_valid) begin
                    n_op      = i_op;
                    n_x       = i_item.touch_x;
                    n_y       = i_item.touch_y;
                    n_ev      = EV_NONE;
                    n_tag     = '0;
                    n_handled = 1'b0;
                    n_ok      = 1'b0;
                    n_eidx    = '0;
                    unique case (i_op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_FIN;
                        end
                        OP_ADD: begin
                            if (r_count < CW'(MAX_AREAS)) begin
                                o_we    = 1'b1;
                                n_count = CW'(r_count + CW'(1));
                                n_ok    = 1'b1;
                            end
                            n_state = S_FIN;
                        end
                        default: begin
                            n_state = (r_count == '0) ? S_FIN : S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read data holds entry r_eidx; write it back when it changes
                o_wr_addr = r_eidx;
                o_wr_data = i_rd_data;
                if (r_op == OP_PRESS) begin
                    if (hit) begin
                        o_we           = 1'b1;
                        o_wr_data.down = 1'b1;
                        if (i_rd_data.press_act) begin
                            stop      = 1'b1;
                            n_ev      = EV_CLICK;
                            n_tag     = i_rd_data.tag;
                            n_handled = 1'b1;
                        end
                    end
                end else begin
                    if (hit && i_rd_data.down) begin
                        o_we           = 1'b1;
                        o_wr_data.down = 1'b0;
                        if (i_rd_data.rel_act) begin
                            stop      = 1'b1;
                            n_ev      = EV_RELEASE;
                            n_tag     = i_rd_data.tag;
                            n_handled = 1'b1;
                        end
                    end
                end
                if (stop || last) begin
                    n_state = S_FIN;
                end else begin
                    n_eidx = AW'(r_eidx + AW'(1));
                end
            end
            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state under reset, payload free running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_eidx    <= n_eidx;
        r_op      <= n_op;
        r_x       <= n_x;
        r_y       <= n_y;
        r_ev      <= n_ev;
        r_tag     <= n_tag;
        r_handled <= n_handled;
        r_ok      <= n_ok;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);

    // Assemble the result; an unhandled press may report lost focus
    always_comb begin
        o_res.event_res = r_ev;
        if ((r_op == OP_PRESS) && !r_handled && i_lfe) begin
            o_res.event_res = EV_LOST;
        end
        o_res.data.hit_tag    = r_tag;
        o_res.data.event_x    = touch_op ? r_x : 16'd0;
        o_res.data.event_y    = touch_op ? r_y : 16'd0;
        o_res.data.handled    = r_handled;
        o_res.data.add_ok     = r_ok;
        o_res.data.area_count = COUNT_W'(r_count);
    end

endmodule

[design/touch_region_hit_table_core.sv]
// Top level of the touch region hit table: config register, entry RAM, sequencer, output stage.
//
// Keeps up to MAX_AREAS rectangles in one RAM and answers each request with one
// result. Clear and add pass from acceptance through S_FIN to the output
// register. Press and release scan the stored entries in order, one entry per
// cycle through the single RAM read port with read-modify-write of the
// held-down mark, and stop at the last entry or the first matching entry with an action.
// One request is in flight at a time; the next is accepted as soon as the
// result has moved into the output register, even while that result waits.
// Write the lost-focus enable only while no request is in flight.
module touch_region_hit_table_core
    import trht_pkg::*;
#(
    parameter int MAX_AREAS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // left, top, right, bottom, area_tag, has_press_action,
    // has_release_action, touch_x, touch_y, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit_tag, event_x, event_y, handled, add_ok, area_count, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // event_res
    output logic [1:0]             m_axis_tuser
);

    localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;

    logic          r_lfe;
    logic          r_out_valid;
    t_result       r_out;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          we;
    t_entry        wr_data;
    t_entry        rd_data;
    logic          res_valid;
    logic          res_take;
    t_result       res;
    t_item         item;

    assign item = t_item'(s_axis_tdata[$bits(t_item)-1:0]);

    // Hold the lost-focus enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfe <= 1'b0;
        end else if (i_cfg_we) begin
            r_lfe <= i_cfg_wdata;
        end
    end

    trht_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_AREAS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    trht_seq #(
        .MAX_AREAS (MAX_AREAS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_item      (item),
        .i_lfe       (r_lfe),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_we        (we),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // Load the output register whenever it is empty or being drained
    assign res_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_res;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out.data);

endmodule

[design/trht_checker.sv]
// Port-level checks of the touch region hit table and their bind to the top level.
module trht_checker
    import trht_pkg::*;
#(
    parameter int MAX_AREAS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    t_res_data res;
    assign res = t_res_data'(m_axis_tdata[$bits(t_res_data)-1:0]);

    // No result straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Handled exactly for click and release events
    a_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.handled ==
            ((m_axis_tuser == EV_CLICK) || (m_axis_tuser == EV_RELEASE))))
        else $error("handled flag disagrees with event");

    // A successful add result carries no event, no tag and no handled flag
    a_add_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.add_ok |->
            (m_axis_tuser == EV_NONE) && (res.hit_tag == 8'd0) && !res.handled)
        else $error("add result carries an event");

    // Count never exceeds the table size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(res.area_count) <= MAX_AREAS))
        else $error("area count beyond table size");

endmodule

bind touch_region_hit_table_core trht_checker #(.MAX_AREAS(MAX_AREAS)) u_trht_checker (.*);
